### hw/rtl/ordered_dither_quantizer_top_macros.svh
// Assertion macros shared by the quantizer checker
`ifndef ORDERED_DITHER_QUANTIZER_TOP_MACROS_SVH
`define ORDERED_DITHER_QUANTIZER_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ODQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered dither quantizer check failed");

// next-cycle implication
`define ODQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered dither quantizer check failed");

`endif

### hw/rtl/odq_pkg.sv
// Types, constants and Bayer lookup for the ordered dither quantizer
package odq_pkg;

  localparam int CHAN_BITS   = 8;
  localparam int LEVEL_BITS  = 9;
  localparam int SPAN_BITS   = 8;
  localparam int PROD_BITS   = 16;
  localparam int NUM_BITS    = 20;
  localparam int SUM_BITS    = 22;
  localparam int OFF_BITS    = 12;
  localparam int QUOT_BITS   = 8;
  localparam int NUM_LANES   = 3;
  // product, clamp, level, then one stage per quotient bit
  localparam int LANE_STAGES = 3 + QUOT_BITS;
  // lane stages plus the merge register
  localparam int PIPE_DEPTH  = LANE_STAGES + 1;

  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;
  localparam logic REG_COLOR_LEVELS = 1'b0;
  localparam logic REG_DITHER       = 1'b1;

  localparam logic [NUM_BITS-1:0] HALF_STEP = 20'd2040;

  // 4x4 Bayer matrix, row-major, index {y[1:0], x[1:0]}
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  typedef struct packed {
    logic [LEVEL_BITS-1:0] color_levels;
    logic                  dither_enable;
  } cfg_t;

  typedef struct packed {
    logic [SPAN_BITS-1:0] span;
    logic [NUM_BITS-1:0]  clamp_hi;
  } lane_ctrl_t;

  // 255*(b-8) for the Bayer entry at the given position
  function automatic logic signed [OFF_BITS-1:0] bayer_offset(input logic [3:0] pos);
    logic signed [OFF_BITS:0] d;
    logic signed [OFF_BITS:0] prod;
    begin
      d    = $signed({9'b0, BAYER[pos]}) - 13'sd8;
      prod = (d <<< 8) - d;
      bayer_offset = prod[OFF_BITS-1:0];
    end
  endfunction

endpackage

### hw/rtl/ordered_dither_quantizer_top.sv
// An accepted pixel passes through the lane pipeline and then the merge register before out_valid rises.
// Throughput: one pixel per cycle; busy is tied low, so the 11-stage lane pipeline never stalls.
// R, G and B run in three lanes; a merge register picks bypass, zero or quantized value.
// Synchronous reset clears color_levels and dither_enable to 0 and empties the pipeline.
// Results cannot be held off by the receiver.
module ordered_dither_quantizer_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     in_red_in,
  input  logic [7:0]                     in_green_in,
  input  logic [7:0]                     in_blue_in,
  input  logic [7:0]                     in_alpha_in,
  input  logic [COORD_BITS-1:0]          in_x_pos,
  input  logic [COORD_BITS-1:0]          in_y_pos,
  output logic                           out_valid,
  output logic [7:0]                     out_red_out,
  output logic [7:0]                     out_green_out,
  output logic [7:0]                     out_blue_out,
  output logic [7:0]                     out_alpha_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [odq_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [odq_pkg::DATA_BITS-1:0]  pwdata,
  output logic [odq_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  localparam int NL = odq_pkg::NUM_LANES;
  localparam int CB = odq_pkg::CHAN_BITS;

  odq_pkg::cfg_t       cfg;
  odq_pkg::lane_ctrl_t ctrl;

  logic                              accept;
  logic signed [odq_pkg::OFF_BITS-1:0] offset;
  logic [CB-1:0]                     lane_in   [NL];
  logic [odq_pkg::QUOT_BITS-1:0]     lane_quot [NL];
  logic [CB-1:0]                     lane_chan [NL];
  logic [CB-1:0]                     merged    [NL];

  logic [odq_pkg::LANE_STAGES-1:0]   vld_r, vld_nxt;
  logic [CB-1:0]                     alpha_r   [odq_pkg::LANE_STAGES];
  logic                              out_valid_r;
  logic [CB-1:0]                     out_chan_r [NL];
  logic [CB-1:0]                     out_alpha_r;
  logic                              bypass;
  logic                              zero_lvl;

  odq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // span = L-1, clamp ceiling = 4080*span
  assign ctrl.span     = cfg.color_levels[odq_pkg::SPAN_BITS-1:0] - 8'd1;
  assign ctrl.clamp_hi = {ctrl.span, 12'b0} - {8'b0, ctrl.span, 4'b0};

  assign offset = cfg.dither_enable ?
                  odq_pkg::bayer_offset({in_y_pos[1:0], in_x_pos[1:0]}) : '0;

  assign lane_in[0] = in_red_in;
  assign lane_in[1] = in_green_in;
  assign lane_in[2] = in_blue_in;

  for (genvar i = 0; i < NL; i++) begin : g_lane
    odq_lane u_lane (
      .clk       (clk),
      .ctrl      (ctrl),
      .chan_in   (lane_in[i]),
      .offset_in (offset),
      .quot_out  (lane_quot[i]),
      .chan_out  (lane_chan[i])
    );
  end

  // track which pipeline slots hold an accepted word
  assign vld_nxt = {vld_r[odq_pkg::LANE_STAGES-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[odq_pkg::LANE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    alpha_r[0] <= in_alpha_in;
    for (int s = 1; s < odq_pkg::LANE_STAGES; s++) begin
      alpha_r[s] <= alpha_r[s-1];
    end
  end

  // merge: bypass for 0 or >=256 levels, zero for a single level
  assign bypass   = (cfg.color_levels == '0) || cfg.color_levels[odq_pkg::LEVEL_BITS-1];
  assign zero_lvl = (cfg.color_levels == 9'd1);

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      if (bypass) begin
        merged[i] = lane_chan[i];
      end else if (zero_lvl) begin
        merged[i] = '0;
      end else begin
        merged[i] = lane_quot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      out_chan_r[i] <= merged[i];
    end
    out_alpha_r <= alpha_r[odq_pkg::LANE_STAGES-1];
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_chan_r[0];
  assign out_green_out = out_chan_r[1];
  assign out_blue_out  = out_chan_r[2];
  assign out_alpha_out = out_alpha_r;

endmodule

### hw/rtl/odq_cfg_regs.sv
// Configuration register file behind the APB-style port
module odq_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [odq_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [odq_pkg::DATA_BITS-1:0]  pwdata,
  output logic [odq_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output odq_pkg::cfg_t                  cfg
);

  logic [odq_pkg::LEVEL_BITS-1:0] levels_r, levels_nxt;
  logic                           dither_r, dither_nxt;
  logic                           wr_en;
  logic                           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    levels_nxt = levels_r;
    dither_nxt = dither_r;
    if (wr_en) begin
      case (reg_sel)
        odq_pkg::REG_COLOR_LEVELS: levels_nxt = pwdata[odq_pkg::LEVEL_BITS-1:0];
        odq_pkg::REG_DITHER:       dither_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= '0;
      dither_r <= 1'b0;
    end else begin
      levels_r <= levels_nxt;
      dither_r <= dither_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      odq_pkg::REG_COLOR_LEVELS:
        prdata = {{(odq_pkg::DATA_BITS-odq_pkg::LEVEL_BITS){1'b0}}, levels_r};
      odq_pkg::REG_DITHER:
        prdata = {{(odq_pkg::DATA_BITS-1){1'b0}}, dither_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.color_levels  = levels_r;
  assign cfg.dither_enable = dither_r;

endmodule

### hw/rtl/odq_lane.sv
// One channel lane: scale, dither, clamp, round to a level, divide back to 0..255
module odq_lane (
  input  logic                                clk,
  input  odq_pkg::lane_ctrl_t                 ctrl,
  input  logic [odq_pkg::CHAN_BITS-1:0]       chan_in,
  input  logic signed [odq_pkg::OFF_BITS-1:0] offset_in,
  output logic [odq_pkg::QUOT_BITS-1:0]       quot_out,
  output logic [odq_pkg::CHAN_BITS-1:0]       chan_out
);

  localparam int QB = odq_pkg::QUOT_BITS;

  logic [odq_pkg::CHAN_BITS-1:0]       chan_r [odq_pkg::LANE_STAGES];
  logic [odq_pkg::PROD_BITS-1:0]       prod_r;
  logic signed [odq_pkg::OFF_BITS-1:0] off_r;
  logic [odq_pkg::NUM_BITS-1:0]        num_r, num_nxt;
  logic [odq_pkg::PROD_BITS-1:0]       t_r, t_nxt;
  logic [odq_pkg::PROD_BITS-1:0]       rem_r [QB];
  logic [QB-1:0]                       quo_r [QB];

  logic signed [odq_pkg::SUM_BITS-1:0] sum_s;
  logic [odq_pkg::NUM_BITS-1:0]        clamped;
  logic [odq_pkg::PROD_BITS-1:0]       q16;
  logic [odq_pkg::PROD_BITS:0]         q255;
  logic [QB-1:0]                       level;

  // stage 1: v*(L-1) and the dither offset
  always_ff @(posedge clk) begin
    prod_r    <= odq_pkg::PROD_BITS'(chan_in) * odq_pkg::PROD_BITS'(ctrl.span);
    off_r     <= offset_in;
    chan_r[0] <= chan_in;
  end

  // stage 2: add offset, clamp to [0, 4080*(L-1)], add half a step
  always_comb begin
    sum_s = $signed({2'b00, prod_r, 4'b0000}) +
            $signed({{(odq_pkg::SUM_BITS-odq_pkg::OFF_BITS){off_r[odq_pkg::OFF_BITS-1]}},
                     off_r});
    if (sum_s[odq_pkg::SUM_BITS-1]) begin
      clamped = '0;
    end else if (sum_s[odq_pkg::SUM_BITS-2:0] > {1'b0, ctrl.clamp_hi}) begin
      clamped = ctrl.clamp_hi;
    end else begin
      clamped = sum_s[odq_pkg::NUM_BITS-1:0];
    end
    num_nxt = clamped + odq_pkg::HALF_STEP;
  end

  // stage 3: level = floor(num/4080) as (num>>4)/255, then level*255
  always_comb begin
    q16   = num_r[odq_pkg::NUM_BITS-1:4];
    q255  = {1'b0, q16} + 17'd1 + {9'b0, q16[15:8]};
    level = q255[15:8];
    t_nxt = {level, 8'b0} - {8'b0, level};
  end

  always_ff @(posedge clk) begin
    num_r     <= num_nxt;
    t_r       <= t_nxt;
    chan_r[1] <= chan_r[0];
    chan_r[2] <= chan_r[1];
  end

  // restoring divide by L-1, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int SH = QB - 1 - k;
    logic [odq_pkg::PROD_BITS-1:0] rem_prev;
    logic [QB-1:0]                 quo_prev;
    logic [odq_pkg::PROD_BITS-1:0] dvs;
    logic                          fits;

    if (k == 0) begin : g_first
      assign rem_prev = t_r;
      assign quo_prev = '0;
    end else begin : g_rest
      assign rem_prev = rem_r[k-1];
      assign quo_prev = quo_r[k-1];
    end

    assign dvs  = odq_pkg::PROD_BITS'(ctrl.span) << SH;
    assign fits = (rem_prev >= dvs);

    always_ff @(posedge clk) begin
      rem_r[k]       <= fits ? (rem_prev - dvs) : rem_prev;
      quo_r[k]       <= {quo_prev[QB-2:0], fits};
      chan_r[3 + k]  <= chan_r[2 + k];
    end
  end

  assign quot_out = quo_r[QB-1];
  assign chan_out = chan_r[odq_pkg::LANE_STAGES-1];

endmodule

### hw/rtl/odq_checker.sv
// Port-level checker for the quantizer, bound to the top level
`include "ordered_dither_quantizer_top_macros.svh"

module odq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_red_in,
  input logic [7:0] in_green_in,
  input logic [7:0] in_blue_in,
  input logic [7:0] in_alpha_in,
  input logic       out_valid,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out,
  input logic [7:0] out_alpha_out
);

  localparam int DEPTH = odq_pkg::PIPE_DEPTH;

  logic same_in;
  logic same_out;

  assign same_in  = (in_red_in == in_green_in) && (in_green_in == in_blue_in);
  assign same_out = (out_red_out == out_green_out) && (out_green_out == out_blue_out);

  // every accepted word comes out after the full pipeline depth
  `ODQ_ASSERT_NEXT(a_word_delivered, start && !busy, ##(DEPTH-1) out_valid)

  // no word appears that was not accepted
  `ODQ_ASSERT_IMPL(a_no_spurious, out_valid, $past(start && !busy && rst_n, DEPTH))

  // alpha travels with its own word
  `ODQ_ASSERT_IMPL(a_alpha_aligned, out_valid, out_alpha_out == $past(in_alpha_in, DEPTH))

  // lanes fed the same value at the same position agree
  `ODQ_ASSERT_IMPL(a_lanes_agree, out_valid && $past(same_in, DEPTH), same_out)

endmodule

bind ordered_dither_quantizer_top odq_checker u_odq_checker (.*);
